// File: sv/bmp_pkg.sv
// Shared types and constants for the BMP-to-RGB565 stream decoder.
// No dependencies; used by bmp_cfg, bmp_parser and bmp24_stream_to_rgb565.
package bmp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ORIGIN_W = 10;
	localparam int unsigned BOX_W    = 11;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned COLOR_W  = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned DIM_W    = 16;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

	localparam logic [BOX_W-1:0] BOX_RESET = 11'd40;
	localparam logic [BOX_W-1:0] BOX_MAX   = 11'd1024;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HDR_OK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HDR_BAD  = 2'd2;

	// header format
	localparam logic [15:0]      BMP_MAGIC  = 16'h4D42;
	localparam logic [7:0]       DEPTH_24   = 8'd24;
	localparam logic [7:0]       RED_MASK   = 8'hF8;
	localparam logic [7:0]       GREEN_MASK = 8'hFC;
	localparam logic [CNT_W-1:0] HEADER_LEN = 32'd34;

	typedef struct packed {
		logic [ORIGIN_W-1:0] origin_x;
		logic [ORIGIN_W-1:0] origin_y;
		logic [BOX_W-1:0]    box_w;   // clamped to BOX_MAX
		logic [BOX_W-1:0]    box_h;   // clamped to BOX_MAX
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} res_t;

endpackage

// File: sv/bmp_cfg.sv
// Configuration registers of the BMP decoder: box origin and clamped box size.
// Depends on bmp_pkg.
module bmp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bmp_pkg::cfg_t                     cfg
);

	logic [bmp_pkg::ORIGIN_W-1:0] origin_x_q, origin_y_q;
	logic [bmp_pkg::BOX_W-1:0]    box_w_q, box_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			box_w_q    <= bmp_pkg::BOX_RESET;
			box_h_q    <= bmp_pkg::BOX_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bmp_pkg::REG_ORIGIN_X:   origin_x_q <= cfg_data[bmp_pkg::ORIGIN_W-1:0];
				bmp_pkg::REG_ORIGIN_Y:   origin_y_q <= cfg_data[bmp_pkg::ORIGIN_W-1:0];
				bmp_pkg::REG_BOX_WIDTH:  box_w_q    <= cfg_data;
				bmp_pkg::REG_BOX_HEIGHT: box_h_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// oversized boxes act as the maximum
	always_comb begin
		cfg.origin_x = origin_x_q;
		cfg.origin_y = origin_y_q;
		cfg.box_w    = (box_w_q > bmp_pkg::BOX_MAX) ? bmp_pkg::BOX_MAX : box_w_q;
		cfg.box_h    = (box_h_q > bmp_pkg::BOX_MAX) ? bmp_pkg::BOX_MAX : box_h_q;
	end

endmodule

// File: sv/bmp_parser.sv
// Byte-wise BMP parser: header checks, offset skip, BGR triple packing, row padding.
// Depends on bmp_pkg. Updates its state on each step and gives at most one result.
module bmp_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [bmp_pkg::BYTE_W-1:0]     data_byte,
	input  logic                           first,
	input  bmp_pkg::cfg_t                  cfg,
	output logic                           res_valid,
	output bmp_pkg::res_t                  res
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SKIP   = 2'd1,
		PH_PIXELS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	logic [bmp_pkg::CNT_W-1:0] byte_count_q, pixel_start_q;
	logic [bmp_pkg::DIM_W-1:0] image_width_q, image_height_q;
	logic [bmp_pkg::DIM_W-1:0] column_count_q, row_count_q;
	logic                      header_good_q;
	phase_t                    phase_q;
	logic [1:0]                triple_q, pad_left_q;
	logic [7:0]                blue_q, green_q;

	logic [bmp_pkg::CNT_W-1:0] bc_n, ps_n;
	logic [bmp_pkg::DIM_W-1:0] iw_n, ih_n, col_n, row_n;
	logic                      hg_n;
	phase_t                    ph_n;
	logic [1:0]                tp_n, pl_n;
	logic [7:0]                blue_n, green_n;

	function automatic logic [bmp_pkg::BOX_W-1:0] min_box(
		input logic [bmp_pkg::DIM_W-1:0] dim,
		input logic [bmp_pkg::BOX_W-1:0] box
	);
		if (dim < {{(bmp_pkg::DIM_W-bmp_pkg::BOX_W){1'b0}}, box})
			return dim[bmp_pkg::BOX_W-1:0];
		return box;
	endfunction

	always_comb begin
		logic [5:0]                k;
		logic                      pix_go;
		logic                      good;
		logic [bmp_pkg::BOX_W-1:0] kw, kh;
		logic [bmp_pkg::DIM_W-1:0] kw_x, kh_x, col_inc, row_inc;

		// a marked byte restarts the parser before it is looked at
		if (first) begin
			bc_n = '0; ps_n = '0; iw_n = '0; ih_n = '0;
			hg_n = 1'b1; ph_n = PH_HEADER;
			col_n = '0; row_n = '0; tp_n = '0; pl_n = '0;
			blue_n = '0; green_n = '0;
		end else begin
			bc_n = byte_count_q; ps_n = pixel_start_q;
			iw_n = image_width_q; ih_n = image_height_q;
			hg_n = header_good_q; ph_n = phase_q;
			col_n = column_count_q; row_n = row_count_q;
			tp_n = triple_q; pl_n = pad_left_q;
			blue_n = blue_q; green_n = green_q;
		end

		res_valid = 1'b0;
		res       = '0;
		pix_go    = 1'b0;
		k         = bc_n[5:0];
		good      = 1'b0;
		kw        = '0;
		kh        = '0;
		kw_x      = '0;
		kh_x      = '0;
		col_inc   = '0;
		row_inc   = '0;

		case (ph_n)
			PH_HEADER: begin
				case (k)
					6'd0:  if (data_byte != bmp_pkg::BMP_MAGIC[7:0])  hg_n = 1'b0;
					6'd1:  if (data_byte != bmp_pkg::BMP_MAGIC[15:8]) hg_n = 1'b0;
					6'd10: ps_n[7:0]   = data_byte;
					6'd11: ps_n[15:8]  = data_byte;
					6'd12: ps_n[23:16] = data_byte;
					6'd13: ps_n[31:24] = data_byte;
					6'd18: iw_n[7:0]   = data_byte;
					6'd19: iw_n[15:8]  = data_byte;
					6'd22: ih_n[7:0]   = data_byte;
					6'd23: ih_n[15:8]  = data_byte;
					6'd26: if (data_byte != 8'd1) hg_n = 1'b0;
					6'd28: if (data_byte != bmp_pkg::DEPTH_24) hg_n = 1'b0;
					6'd27, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33:
						if (data_byte != 8'd0) hg_n = 1'b0;
					default: ;
				endcase
				bc_n = bc_n + 1'b1;
				if (k == 6'(bmp_pkg::HEADER_LEN - 1)) begin
					good      = hg_n && (ps_n >= bmp_pkg::HEADER_LEN);
					kw        = min_box(iw_n, cfg.box_w);
					kh        = min_box(ih_n, cfg.box_h);
					res_valid = 1'b1;
					if (good) begin
						res.kind = bmp_pkg::KIND_HDR_OK;
						res.last = (kw == '0) || (kh == '0);
						ph_n     = res.last ? PH_DONE : PH_SKIP;
					end else begin
						res.kind = bmp_pkg::KIND_HDR_BAD;
						res.last = 1'b1;
						ph_n     = PH_DONE;
					end
				end
			end
			PH_SKIP: begin
				if (bc_n < ps_n) begin
					bc_n = bc_n + 1'b1;
				end else begin
					ph_n   = PH_PIXELS;
					pix_go = 1'b1;
				end
			end
			PH_PIXELS: pix_go = 1'b1;
			default: ;
		endcase

		if (pix_go) begin
			kw   = min_box(iw_n, cfg.box_w);
			kh   = min_box(ih_n, cfg.box_h);
			kw_x = {{(bmp_pkg::DIM_W-bmp_pkg::BOX_W){1'b0}}, kw};
			kh_x = {{(bmp_pkg::DIM_W-bmp_pkg::BOX_W){1'b0}}, kh};
			row_inc = row_n + 1'b1;
			col_inc = col_n + 1'b1;
			if (pl_n != 2'd0) begin
				// row padding
				pl_n = pl_n - 1'b1;
				if (pl_n == 2'd0) begin
					col_n = '0;
					row_n = row_inc;
					if (row_inc >= ih_n) ph_n = PH_DONE;
				end
			end else if (tp_n == 2'd0) begin
				blue_n = data_byte;
				tp_n   = 2'd1;
			end else if (tp_n == 2'd1) begin
				green_n = data_byte;
				tp_n    = 2'd2;
			end else begin
				tp_n = 2'd0;
				if (col_n < kw_x && row_n < kh_x) begin
					res_valid = 1'b1;
					res.kind  = bmp_pkg::KIND_PIXEL;
					res.pos_x = {1'b0, cfg.origin_x} + col_n[bmp_pkg::POS_W-1:0];
					res.pos_y = {1'b0, cfg.origin_y} + cfg.box_h - 11'd1
					            - row_n[bmp_pkg::POS_W-1:0];
					res.color = {data_byte[7:3], green_n[7:2], blue_n[7:3]};
					res.last  = (col_inc == kw_x) && (row_inc == kh_x);
				end
				if (res_valid && res.last) begin
					ph_n = PH_DONE;
				end else begin
					col_n = col_inc;
					if (col_inc >= iw_n) begin
						// pad to 4 bytes: 3*w mod 4 leaves w mod 4 bytes
						if (iw_n[1:0] != 2'd0) begin
							pl_n = iw_n[1:0];
						end else begin
							col_n = '0;
							row_n = row_inc;
							if (row_inc >= ih_n) ph_n = PH_DONE;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			pixel_start_q  <= '0;
			image_width_q  <= '0;
			image_height_q <= '0;
			header_good_q  <= 1'b1;
			phase_q        <= PH_HEADER;
			column_count_q <= '0;
			row_count_q    <= '0;
			triple_q       <= '0;
			pad_left_q     <= '0;
		end else if (step) begin
			byte_count_q   <= bc_n;
			pixel_start_q  <= ps_n;
			image_width_q  <= iw_n;
			image_height_q <= ih_n;
			header_good_q  <= hg_n;
			phase_q        <= ph_n;
			column_count_q <= col_n;
			row_count_q    <= row_n;
			triple_q       <= tp_n;
			pad_left_q     <= pl_n;
		end
	end

	// held color bytes are always written before use
	always_ff @(posedge clk) begin
		if (step) begin
			blue_q  <= blue_n;
			green_q <= green_n;
		end
	end

endmodule

// File: sv/bmp24_stream_to_rgb565.sv
// Top level of the 24-bit BMP byte stream to RGB565 pixel stream decoder.
// Depends on bmp_pkg, bmp_cfg and bmp_parser.

// Feed a BMP file one byte per request on the input channel, with first set
// on byte 0 of each file (after reset the parser already expects byte 0).
// At header byte 33 one result reports the header accepted or rejected;
// a rejected header (bad magic, planes, depth, compression, or data offset
// below 34) carries last and the rest of the file is ignored. After an
// accepted header the bytes up to the data offset are skipped, then each
// blue/green/red triple inside the box gives one pixel result at
// (origin_x + column, origin_y + box_height - 1 - row), rows bottom-up.
// Row padding and pixels outside the box are consumed without a result; the
// last kept pixel (or an accepted header with nothing to show) carries last,
// after which bytes are ignored until the next first. The block takes one
// byte per clock as long as results are taken: a byte is held in the input
// register, is parsed by the single-pass logic in bmp_parser and its result
// lands in the output register. Configuration writes take effect at once and
// should be made only while the block is idle; box sizes above 1024 act as
// 1024.
module bmp24_stream_to_rgb565 (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [bmp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// byte requests
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bmp_pkg::BYTE_W-1:0]        data_byte,
	input  logic                              first,
	// result requests
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bmp_pkg::KIND_W-1:0]        kind,
	output logic [bmp_pkg::POS_W-1:0]         pos_x,
	output logic [bmp_pkg::POS_W-1:0]         pos_y,
	output logic [bmp_pkg::COLOR_W-1:0]       color,
	output logic                              last
);

	bmp_pkg::cfg_t cfg;
	bmp_pkg::res_t res, res_q;
	logic          res_valid;

	// input register
	logic                       valid_s1;
	logic [bmp_pkg::BYTE_W-1:0] byte_s1;
	logic                       first_s1;

	logic out_valid_q;
	logic step;

	// the held byte is parsed when the output register is free or draining
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	bmp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bmp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.first     (first_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign pos_x     = res_q.pos_x;
	assign pos_y     = res_q.pos_y;
	assign color     = res_q.color;
	assign last      = res_q.last;

endmodule
